// ----- rtl/brmic_pkg.sv -----
// Package for the bank register mapper with interrupt counter.
// Holds the bus decode constants, command codes, item types and the window decode.
// No dependencies.
`timescale 1ns / 1ps

package brmic_pkg;

  localparam logic [15:0] PORT_MASK    = 16'hE000;
  localparam logic [15:0] PORT_COMMAND = 16'h8000;
  localparam logic [15:0] PORT_PARAM   = 16'hA000;
  localparam logic [15:0] COUNT_RELOAD = 16'hFFFF;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam logic [3:0] CMD_CHR_FIRST = 4'd0;
  localparam logic [3:0] CMD_WINDOW    = 4'd8;
  localparam logic [3:0] CMD_PRG_LAST  = 4'd11;
  localparam logic [3:0] CMD_MIRROR    = 4'd12;
  localparam logic [3:0] CMD_IRQ_EN    = 4'd13;
  localparam logic [3:0] CMD_COUNT_LO  = 4'd14;
  localparam logic [3:0] CMD_COUNT_HI  = 4'd15;

  localparam int NUM_SLOTS = 12;

  localparam logic [1:0] WIN_ROM  = 2'd0;
  localparam logic [1:0] WIN_OPEN = 2'd1;
  localparam logic [1:0] WIN_RAM  = 2'd2;

  typedef struct packed {
    logic        action;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  cycles;
  } in_item_t;

  typedef struct packed {
    logic        bank_written;
    logic [3:0]  bank_slot;
    logic [7:0]  bank_value;
    logic [1:0]  mirror_mode;
    logic [1:0]  window_mode;
    logic        irq_fired;
    logic        irq_enabled;
    logic [15:0] irq_counter;
  } res_t;

  // Bit 6 clear maps ROM; bit 6 set maps RAM when bit 7 is set, else open bus.
  function automatic logic [1:0] window_decode(input logic [7:0] w);
    logic [1:0] mode;
    if (!w[6]) begin
      mode = WIN_ROM;
    end else if (w[7]) begin
      mode = WIN_RAM;
    end else begin
      mode = WIN_OPEN;
    end
    return mode;
  endfunction

endpackage

// ----- rtl/brmic_in_if.sv -----
// Input channel of the mapper: one bus write or cycle tick per transfer.
// Standalone interface with source and sink modports; no dependencies.
`timescale 1ns / 1ps

interface brmic_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] address;
  logic [7:0]  data;
  logic [7:0]  cycles;

  modport source (output valid, action, address, data, cycles, input ready);
  modport sink (input valid, action, address, data, cycles, output ready);
endinterface

// ----- rtl/brmic_out_if.sv -----
// Result channel of the mapper: one result per accepted input transfer.
// Standalone interface with source and sink modports; no dependencies.
`timescale 1ns / 1ps

interface brmic_out_if;
  logic        valid;
  logic        ready;
  logic        bank_written;
  logic [3:0]  bank_slot;
  logic [7:0]  bank_value;
  logic [1:0]  mirror_mode;
  logic [1:0]  window_mode;
  logic        irq_fired;
  logic        irq_enabled;
  logic [15:0] irq_counter;

  modport source (output valid, bank_written, bank_slot, bank_value, mirror_mode,
                  window_mode, irq_fired, irq_enabled, irq_counter, input ready);
  modport sink (input valid, bank_written, bank_slot, bank_value, mirror_mode,
                window_mode, irq_fired, irq_enabled, irq_counter, output ready);
endinterface

// ----- rtl/brmic_regs.sv -----
// Mapper register file, command decode and interrupt counter.
// Updates its state on one item when upd is high and gives the result of that item.
// Depends on brmic_pkg.
`timescale 1ns / 1ps

module brmic_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              upd,
  input  brmic_pkg::in_item_t item,
  output brmic_pkg::res_t   res
);

  logic [3:0]  command;
  logic [3:0]  command_next;
  logic [7:0]  banks [brmic_pkg::NUM_SLOTS];
  logic [7:0]  banks_next [brmic_pkg::NUM_SLOTS];
  logic [1:0]  mirroring;
  logic [1:0]  mirroring_next;
  logic        irq_en;
  logic        irq_en_next;
  logic [15:0] irq_count;
  logic [15:0] irq_count_next;
  logic        written;
  logic        fired;

  always_comb begin
    command_next   = command;
    banks_next     = banks;
    mirroring_next = mirroring;
    irq_en_next    = irq_en;
    irq_count_next = irq_count;
    written        = 1'b0;
    fired          = 1'b0;
    if (item.action == brmic_pkg::ACT_WRITE) begin
      if ((item.address & brmic_pkg::PORT_MASK) == brmic_pkg::PORT_COMMAND) begin
        command_next = item.data[3:0];
      end else if ((item.address & brmic_pkg::PORT_MASK) == brmic_pkg::PORT_PARAM) begin
        unique case (command) inside
          [brmic_pkg::CMD_CHR_FIRST:brmic_pkg::CMD_PRG_LAST]: begin
            banks_next[command] = item.data;
            written             = 1'b1;
          end
          brmic_pkg::CMD_MIRROR: begin
            mirroring_next = item.data[1:0];
          end
          brmic_pkg::CMD_IRQ_EN: begin
            irq_en_next = (item.data != 8'd0);
          end
          brmic_pkg::CMD_COUNT_LO: begin
            irq_count_next = {irq_count[15:8], item.data};
          end
          brmic_pkg::CMD_COUNT_HI: begin
            irq_count_next = {item.data, irq_count[7:0]};
          end
          default: begin
          end
        endcase
      end
    end else if (irq_en) begin
      if ({8'd0, item.cycles} >= irq_count) begin
        fired          = 1'b1;
        irq_en_next    = 1'b0;
        irq_count_next = brmic_pkg::COUNT_RELOAD;
      end else begin
        irq_count_next = irq_count - {8'd0, item.cycles};
      end
    end
  end

  always_comb begin
    res.bank_written = written;
    res.bank_slot    = written ? command : 4'd0;
    res.bank_value   = written ? item.data : 8'd0;
    res.mirror_mode  = mirroring_next;
    res.window_mode  = brmic_pkg::window_decode(banks_next[brmic_pkg::CMD_WINDOW]);
    res.irq_fired    = fired;
    res.irq_enabled  = irq_en_next;
    res.irq_counter  = irq_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command   <= 4'd0;
      mirroring <= 2'd0;
      irq_en    <= 1'b0;
      irq_count <= 16'd0;
      for (int i = 0; i < brmic_pkg::NUM_SLOTS; i++) begin
        banks[i] <= 8'd0;
      end
    end else if (upd) begin
      command   <= command_next;
      mirroring <= mirroring_next;
      irq_en    <= irq_en_next;
      irq_count <= irq_count_next;
      banks     <= banks_next;
    end
  end

  a_fire_reload: assert property (@(posedge clk) disable iff (rst)
    upd && res.irq_fired |=> !irq_en && irq_count == brmic_pkg::COUNT_RELOAD)
    else $error("interrupt did not disable and reload the counter");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !upd |=> $stable(irq_count) && $stable(irq_en) && $stable(command)
             && $stable(mirroring))
    else $error("mapper state changed without an item");

  a_fire_needs_tick: assert property (@(posedge clk) disable iff (rst)
    res.irq_fired |-> item.action == brmic_pkg::ACT_TICK && irq_en)
    else $error("interrupt raised outside an enabled tick");

  a_bank_needs_write: assert property (@(posedge clk) disable iff (rst)
    res.bank_written |-> item.action == brmic_pkg::ACT_WRITE
                         && res.bank_slot <= brmic_pkg::CMD_PRG_LAST)
    else $error("bank write flagged on a tick or an invalid slot");

endmodule

// ----- rtl/bank_register_mapper_with_irq_counter.sv -----
// Top level of the bank register mapper with interrupt counter.
// Input register, brmic_regs update stage and result register.
// Depends on brmic_pkg, brmic_in_if, brmic_out_if and brmic_regs.
//
//   Port     Direction  Moves
//   bus      sink       bus write or cycle tick (action, address, data, cycles)
//   result   source     bank write, mirroring, window mode, interrupt status
//
// One transfer per cycle unless the result stalls; path: input then result register.
// The state update happens when an item leaves the input register for the result
// register, so each item sees the state that all earlier items left.
// A stalled result holds the result register and then the input register.
// Synchronous reset clears the mapper state and both valid flags.
`timescale 1ns / 1ps

module bank_register_mapper_with_irq_counter (
  input  logic          clk,
  input  logic          rst,
  brmic_in_if.sink      bus,
  brmic_out_if.source   result
);

  logic                s1_valid;
  brmic_pkg::in_item_t s1_item;
  logic                out_valid;
  brmic_pkg::res_t     out_item;
  brmic_pkg::res_t     res;
  logic                advance;

  assign advance   = s1_valid && (!out_valid || result.ready);
  assign bus.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bus.ready) begin
      s1_valid <= bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bus.ready && bus.valid) begin
      s1_item.action  <= bus.action;
      s1_item.address <= bus.address;
      s1_item.data    <= bus.data;
      s1_item.cycles  <= bus.cycles;
    end
  end

  brmic_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .upd  (advance),
    .item (s1_item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= res;
    end
  end

  assign result.valid        = out_valid;
  assign result.bank_written = out_item.bank_written;
  assign result.bank_slot    = out_item.bank_slot;
  assign result.bank_value   = out_item.bank_value;
  assign result.mirror_mode  = out_item.mirror_mode;
  assign result.window_mode  = out_item.window_mode;
  assign result.irq_fired    = out_item.irq_fired;
  assign result.irq_enabled  = out_item.irq_enabled;
  assign result.irq_counter  = out_item.irq_counter;

endmodule

// ----- dv/tb.sv -----
// Testbench for bank_register_mapper_with_irq_counter: directed and random bus writes and ticks.
// A scoreboard class predicts every result and checks it field by field against the result port.
// Depends on brmic_pkg, brmic_in_if, brmic_out_if and the mapper RTL.
`timescale 1ns / 1ps

module tb;
  import brmic_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_AFTER = 300;
  localparam int ITEM_COUNT = 700;

  class mapper_tracker;
    logic [3:0]  cmd_sel;
    logic [7:0]  chr_bank [8];
    logic [7:0]  win_reg;
    logic [7:0]  prg_bank [3];
    logic [1:0]  mirror;
    logic        irq_on;
    logic [15:0] irq_cnt;
    res_t        expected_status [$];
    int          accepted;
    int          errors;

    function new();
      cmd_sel = '0;
      foreach (chr_bank[i]) chr_bank[i] = '0;
      win_reg = '0;
      foreach (prg_bank[i]) prg_bank[i] = '0;
      mirror = '0;
      irq_on = 1'b0;
      irq_cnt = '0;
      accepted = 0;
      errors = 0;
    endfunction

    function int backlog();
      return expected_status.size();
    endfunction

    function void note_transfer(in_item_t it);
      res_t want;
      logic [3:0] sel;
      logic [3:0] prg_idx;
      want = '0;
      sel = cmd_sel;
      prg_idx = sel - CMD_WINDOW - 4'd1;
      accepted++;
      if (it.action == ACT_WRITE) begin
        if ((it.address & PORT_MASK) == PORT_COMMAND) begin
          cmd_sel = it.data[3:0];
        end else if ((it.address & PORT_MASK) == PORT_PARAM) begin
          if (sel < CMD_WINDOW) begin
            chr_bank[sel[2:0]] = it.data;
          end else if (sel == CMD_WINDOW) begin
            win_reg = it.data;
          end else if (sel <= CMD_PRG_LAST) begin
            prg_bank[prg_idx[1:0]] = it.data;
          end else if (sel == CMD_MIRROR) begin
            mirror = it.data[1:0];
          end else if (sel == CMD_IRQ_EN) begin
            irq_on = |it.data;
          end else if (sel == CMD_COUNT_LO) begin
            irq_cnt[7:0] = it.data;
          end else begin
            irq_cnt[15:8] = it.data;
          end
          if (sel <= CMD_PRG_LAST) begin
            want.bank_written = 1'b1;
            want.bank_slot = sel;
            want.bank_value = it.data;
          end
        end
      end else if (irq_on) begin
        if ({8'h00, it.cycles} >= irq_cnt) begin
          want.irq_fired = 1'b1;
          irq_on = 1'b0;
          irq_cnt = COUNT_RELOAD;
        end else begin
          irq_cnt = irq_cnt - {8'h00, it.cycles};
        end
      end
      want.mirror_mode = mirror;
      if (!win_reg[6]) begin
        want.window_mode = WIN_ROM;
      end else if (win_reg[7]) begin
        want.window_mode = WIN_RAM;
      end else begin
        want.window_mode = WIN_OPEN;
      end
      want.irq_enabled = irq_on;
      want.irq_counter = irq_cnt;
      expected_status.push_back(want);
    endfunction

    function void field_check(string field, int unsigned want, int unsigned seen);
      if (want != seen) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        errors++;
      end
    endfunction

    function void check_status(res_t seen);
      res_t want;
      if (expected_status.size() == 0) begin
        $error("result transfer with no expected result waiting");
        errors++;
      end else begin
        want = expected_status.pop_front();
        field_check("bank_written", want.bank_written, seen.bank_written);
        field_check("bank_slot", want.bank_slot, seen.bank_slot);
        field_check("bank_value", want.bank_value, seen.bank_value);
        field_check("mirror_mode", want.mirror_mode, seen.mirror_mode);
        field_check("window_mode", want.window_mode, seen.window_mode);
        field_check("irq_fired", want.irq_fired, seen.irq_fired);
        field_check("irq_enabled", want.irq_enabled, seen.irq_enabled);
        field_check("irq_counter", want.irq_counter, seen.irq_counter);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit burst_mode;
  mapper_tracker tracker;

  brmic_in_if bus_if ();
  brmic_out_if res_if ();

  bank_register_mapper_with_irq_counter dut (
    .clk    (clk),
    .rst    (rst),
    .bus    (bus_if),
    .result (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 50) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic push_item(input in_item_t it);
    int gap;
    bus_if.valid <= 1'b1;
    bus_if.action <= it.action;
    bus_if.address <= it.address;
    bus_if.data <= it.data;
    bus_if.cycles <= it.cycles;
    @(posedge clk);
    while (!bus_if.ready) @(posedge clk);
    tracker.note_transfer(it);
    gap = idle_gap();
    if (gap > 0) begin
      bus_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic bus_write(input logic [15:0] addr, input logic [7:0] value);
    in_item_t it;
    it.action = ACT_WRITE;
    it.address = addr;
    it.data = value;
    it.cycles = 8'($urandom_range(0, 255));
    push_item(it);
  endtask

  task automatic select_cmd(input logic [3:0] cmd);
    logic [3:0] junk;
    junk = 4'($urandom_range(0, 15));
    bus_write(PORT_COMMAND | 16'($urandom_range(0, 16'h1FFF)), {junk, cmd});
  endtask

  task automatic param_write(input logic [7:0] value);
    bus_write(PORT_PARAM | 16'($urandom_range(0, 16'h1FFF)), value);
  endtask

  task automatic cycle_tick(input logic [7:0] n);
    in_item_t it;
    it.action = ACT_TICK;
    it.address = 16'($urandom_range(0, 16'hFFFF));
    it.data = 8'($urandom_range(0, 255));
    it.cycles = n;
    push_item(it);
  endtask

  task automatic drain_results();
    bus_if.valid <= 1'b0;
    while (tracker.backlog() != 0) @(posedge clk);
  endtask

  // Tick lengths that land exactly on, just short of, or past the current count.
  function automatic logic [7:0] pick_cycles();
    int r;
    logic [15:0] c;
    r = $urandom_range(0, 5);
    c = tracker.irq_cnt;
    if (r == 0) begin
      return (c > 16'd255) ? 8'hFF : c[7:0];
    end else if (r == 1) begin
      c = (c > 16'd0 && c <= 16'd256) ? c - 16'd1 : 16'd0;
      return c[7:0];
    end else if (r == 2) begin
      return 8'hFF;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_sequence();
    in_item_t it;
    int kind;
    logic [3:0] cmd;
    logic [7:0] hi;
    kind = $urandom_range(0, 19);
    if (kind < 8) begin
      cmd = 4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 12));
      select_cmd(cmd);
      repeat ($urandom_range(1, 3)) param_write(8'($urandom_range(0, 255)));
    end else if (kind < 14) begin
      select_cmd(CMD_COUNT_LO);
      param_write(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) < 6) begin
        hi = 8'h00;
      end else if ($urandom_range(0, 3) != 0) begin
        hi = 8'($urandom_range(1, 3));
      end else begin
        hi = 8'($urandom_range(0, 255));
      end
      select_cmd(CMD_COUNT_HI);
      param_write(hi);
      select_cmd(CMD_IRQ_EN);
      param_write(8'($urandom_range(1, 255)));
      repeat ($urandom_range(1, 10)) begin
        if ($urandom_range(0, 5) == 0) begin
          select_cmd(4'($urandom_range(0, 11)));
          param_write(8'($urandom_range(0, 255)));
        end
        cycle_tick(pick_cycles());
      end
    end else if (kind < 17) begin
      select_cmd(CMD_IRQ_EN);
      param_write(8'($urandom_range(1, 255)));
      cycle_tick(8'($urandom_range(0, 255)));
      param_write(8'h00);
      cycle_tick(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        it.action = 1'($urandom_range(0, 1));
        it.address = 16'($urandom_range(0, 16'hFFFF));
        it.data = 8'($urandom_range(0, 255));
        it.cycles = 8'($urandom_range(0, 255));
        push_item(it);
      end
    end
  endtask

  initial begin
    int next_drain;
    tracker = new();
    burst_mode = 1'b0;
    rst <= 1'b1;
    bus_if.valid <= 1'b0;
    bus_if.action <= ACT_WRITE;
    bus_if.address <= '0;
    bus_if.data <= '0;
    bus_if.cycles <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cycle_tick(8'h00);
    bus_write(PORT_COMMAND | 16'h1FFF, {4'hF, CMD_COUNT_HI});
    bus_write(PORT_PARAM, 8'h00);
    bus_write(PORT_COMMAND, {4'hF, CMD_COUNT_LO});
    bus_write(PORT_PARAM | 16'h1FFF, 8'h00);
    bus_write(PORT_COMMAND, {4'h0, CMD_IRQ_EN});
    bus_write(PORT_PARAM, 8'h80);
    cycle_tick(8'h00);
    cycle_tick(8'hFF);
    bus_write(PORT_COMMAND, {4'h0, CMD_WINDOW - 4'd1});
    bus_write(PORT_PARAM, 8'hFF);
    bus_write(PORT_COMMAND, {4'h0, CMD_CHR_FIRST});
    bus_write(PORT_PARAM, 8'h00);
    bus_write(PORT_COMMAND, {4'h0, CMD_WINDOW});
    bus_write(PORT_PARAM, 8'hC0);
    bus_write(PORT_PARAM, 8'h40);
    bus_write(PORT_PARAM, 8'h80);
    bus_write(PORT_COMMAND, {4'h0, CMD_PRG_LAST});
    bus_write(PORT_PARAM, 8'hFF);
    bus_write(PORT_COMMAND, {4'h0, CMD_MIRROR});
    bus_write(PORT_PARAM, 8'hFF);
    bus_write(16'h0000, 8'hFF);
    bus_write(16'hFFFF, 8'hFF);
    bus_write(PORT_COMMAND, {4'h0, CMD_IRQ_EN});
    bus_write(PORT_PARAM, 8'h00);
    drain_results();

    next_drain = 200;
    while (tracker.accepted < ITEM_COUNT) begin
      burst_mode = ($urandom_range(0, 7) == 0);
      if (tracker.accepted >= next_drain) begin
        drain_results();
        next_drain += 200;
      end
      random_sequence();
    end

    bus_if.valid <= 1'b0;
    while (tracker.backlog() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    bit held;
    held = 1'b0;
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (!held && tracker.accepted >= HOLD_AFTER) begin
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(30, 60)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
        res_if.ready <= 1'b0;
        if ($urandom_range(0, 9) < 8) begin
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          repeat ($urandom_range(8, 40)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t seen;
    if (!rst && res_if.valid && res_if.ready) begin
      seen = {res_if.bank_written, res_if.bank_slot, res_if.bank_value, res_if.mirror_mode,
              res_if.window_mode, res_if.irq_fired, res_if.irq_enabled, res_if.irq_counter};
      tracker.check_status(seen);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst !== 1'b0 || (bus_if.valid && bus_if.ready) || (res_if.valid && res_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("FAIL");
    $finish;
  end

endmodule
